// ===== hw/rtl/rsakg_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsakg_pkg
// Shared types and constants for the small RSA key generator.
// ----------------------------------------------------------------------------
package rsakg_pkg;

    localparam int PRIME_BITS = 32;
    localparam int WORD_BITS  = 64;
    localparam int CNT_BITS   = 7;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_NO_E  = 2'd1;
    localparam logic [1:0] STATUS_NO_INV = 2'd2;

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_PHI,
        ST_GCD_START,
        ST_DIV,
        ST_GCD_STEP,
        ST_EE_START,
        ST_EE_DIV,
        ST_EE_MUL,
        ST_EE_STEP,
        ST_OUT
    } state_t;

endpackage : rsakg_pkg
`default_nettype wire

// ===== hw/rtl/rsa_small_key_generation_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rsa_small_key_generation_top
// RSA key generation from two small primes with a shared bit-serial unit.
// ----------------------------------------------------------------------------
// One transaction of (p, q) yields one of (n, e, d, status). All arithmetic
// runs through one 64-bit add/subtract/shift datapath: products by
// shift-and-add, divisions by restoring division. The e search costs one
// gcd (a chain of divisions) per candidate; the extended Euclid step costs
// a division plus a modular shift-add product. The run time of a key is
// set by the number of divisions. s_tready is high only while the block is
// idle and no result is pending; the result is held in m_tdata until taken.
module rsa_small_key_generation_top (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [63:0]  s_tdata,   // prime_p[31:0], prime_q[63:32]
    output logic         m_tvalid,
    input  wire          m_tready,
    output logic [199:0] m_tdata    // modulus, public_exponent, private_exponent, status
);
    import rsakg_pkg::*;

    state_t state_reg, state_next;
    word_t  phi_reg, phi_next;
    word_t  n_reg, n_next;
    word_t  e_reg, e_next;
    word_t  ra_reg, ra_next;       // remainder a / gcd a
    word_t  rb_reg, rb_next;
    word_t  co_reg, co_next;
    word_t  cn_reg, cn_next;
    word_t  x_reg, x_next;         // multiplicand / dividend shift
    word_t  y_reg, y_next;         // multiplier / quotient
    word_t  acc_reg, acc_next;     // product / partial remainder
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic   mode_reg, mode_next;   // 0: phi product pass, 1: n product
    logic [199:0] out_reg, out_next;
    logic   mv_reg, mv_next;

    word_t  pm, qm;
    logic [WORD_BITS:0] trial;
    word_t  room, dbl, mroom, dsel;

    assign s_tready = (state_reg == ST_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
        phi_reg <= phi_next; n_reg <= n_next; e_reg <= e_next;
        ra_reg <= ra_next; rb_reg <= rb_next; co_reg <= co_next;
        cn_reg <= cn_next; x_reg <= x_next; y_reg <= y_next;
        acc_reg <= acc_next; cnt_reg <= cnt_next; mode_reg <= mode_next;
        out_reg <= out_next;
    end

    always_comb begin
        state_next = state_reg; phi_next = phi_reg; n_next = n_reg;
        e_next = e_reg; ra_next = ra_reg; rb_next = rb_reg;
        co_next = co_reg; cn_next = cn_reg; x_next = x_reg; y_next = y_reg;
        acc_next = acc_reg; cnt_next = cnt_reg; mode_next = mode_reg;
        out_next = out_reg; mv_next = mv_reg;
        pm = {{(WORD_BITS-PRIME_BITS){1'b0}}, s_tdata[PRIME_BITS-1:0]};
        qm = {{(WORD_BITS-PRIME_BITS){1'b0}}, s_tdata[32+PRIME_BITS-1:32]};
        trial = {acc_reg, x_reg[WORD_BITS-1]} - {1'b0, rb_reg};
        // modular add step of ee product: acc + x mod phi, x doubling
        room  = phi_reg - x_reg;
        mroom = phi_reg - acc_reg;
        dbl   = (x_reg >= room) ? x_reg - room : x_reg + x_reg;
        dsel  = (acc_reg >= room) ? acc_reg - room : acc_reg + x_reg;
        if (mv_reg && m_tready) mv_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !mv_reg) begin
                    x_next = pm; y_next = qm; acc_next = '0;
                    ra_next = pm - 64'd1; rb_next = qm - 64'd1;
                    mode_next = 1'b1; cnt_next = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                // plain shift-and-add, modulo 2^64
                if (y_reg[0]) acc_next = acc_reg + x_reg;
                x_next = x_reg << 1;
                y_next = y_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WORD_BITS-1)) begin
                    if (mode_reg) begin
                        n_next = acc_next; mode_next = 1'b0;
                        x_next = ra_reg; y_next = rb_reg; acc_next = '0;
                        cnt_next = '0;
                    end else state_next = ST_PHI;
                end
            end
            ST_PHI: begin
                phi_next = acc_reg;
                if (acc_reg < 64'd3) begin
                    out_next = {6'd0, STATUS_NO_E, 64'd0, 64'd0, n_reg};
                    mv_next = 1'b1; state_next = ST_IDLE;
                end else begin
                    e_next = 64'd2; state_next = ST_GCD_START;
                end
            end
            ST_GCD_START: begin
                if (e_reg == phi_reg) begin
                    out_next = {6'd0, STATUS_NO_E, 64'd0, 64'd0, n_reg};
                    mv_next = 1'b1; state_next = ST_IDLE;
                end else begin
                    ra_next = e_reg; rb_next = phi_reg;
                    state_next = ST_GCD_STEP;
                end
            end
            ST_GCD_STEP: begin
                if (rb_reg == '0) begin
                    if (ra_reg == 64'd1) state_next = ST_EE_START;
                    else begin
                        e_next = e_reg + 64'd1; state_next = ST_GCD_START;
                    end
                end else begin
                    x_next = ra_reg; acc_next = '0; y_next = '0; cnt_next = '0;
                    mode_next = 1'b0; state_next = ST_DIV;
                end
            end
            ST_DIV, ST_EE_DIV: begin
                // restoring division of x by rb
                x_next = x_reg << 1;
                if (!trial[WORD_BITS]) begin
                    acc_next = trial[WORD_BITS-1:0];
                    y_next = {y_reg[WORD_BITS-2:0], 1'b1};
                end else begin
                    acc_next = {acc_reg[WORD_BITS-2:0], x_reg[WORD_BITS-1]};
                    y_next = {y_reg[WORD_BITS-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(WORD_BITS-1)) begin
                    if (state_reg == ST_DIV) begin
                        ra_next = rb_reg; rb_next = acc_next;
                        state_next = ST_GCD_STEP;
                    end else begin
                        ra_next = rb_reg; rb_next = acc_next;
                        // product quo*cn mod phi; quo reduced by compare loop
                        x_next = cn_reg; acc_next = '0; cnt_next = '0;
                        state_next = ST_EE_MUL;
                    end
                end
            end
            ST_EE_START: begin
                ra_next = phi_reg; rb_next = e_reg; co_next = '0; cn_next = 64'd1;
                state_next = ST_EE_STEP;
            end
            ST_EE_STEP: begin
                if (rb_reg == '0) begin
                    if (ra_reg == 64'd1)
                        out_next = {6'd0, STATUS_OK, co_reg, e_reg, n_reg};
                    else
                        out_next = {6'd0, STATUS_NO_INV, 64'd0, e_reg, n_reg};
                    mv_next = 1'b1; state_next = ST_IDLE;
                end else begin
                    x_next = ra_reg; acc_next = '0; y_next = '0; cnt_next = '0;
                    state_next = ST_EE_DIV;
                end
            end
            ST_EE_MUL: begin
                // quotient y is reduced below phi by repeated subtraction before the product starts
                if (cnt_reg == '0 && y_reg >= phi_reg) y_next = y_reg - phi_reg;
                else begin
                    if (y_reg[0]) acc_next = dsel;
                    x_next = dbl;
                    y_next = y_reg >> 1;
                    if (y_reg == '0) begin
                        co_next = cn_reg;
                        cn_next = (co_reg >= acc_reg) ? co_reg - acc_reg
                                                       : co_reg + mroom;
                        state_next = ST_EE_STEP;
                    end
                    cnt_next = CNT_BITS'(1);
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule : rsa_small_key_generation_top
`default_nettype wire
